/* sv/eslc_pkg.sv */
// ----------------------------------------------------------------------------
// eslc_pkg
// Shared sizes, codes and control structures of the expert slot LRU cache.
// ----------------------------------------------------------------------------
package eslc_pkg;

  // Sizes of the id space, the slot set and the time stamps.
  localparam int NUM_EXPERTS = 256;
  localparam int NUM_SLOTS   = 64;
  localparam int ID_W        = $clog2(NUM_EXPERTS);
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int NSLOT_W     = SLOT_W + 1;
  localparam int NEXP_W      = ID_W + 1;
  localparam int STAMP_W     = 32;
  localparam int TOTAL_W     = 32;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_ID  = 2'd1;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

  // Configuration register indices.
  localparam logic REG_SLOTS   = 1'b0;
  localparam logic REG_EXPERTS = 1'b1;

  // Commands to the stamp store and victim search.
  typedef struct packed {
    logic               go;          // start a victim search
    logic               first;       // batch start: pins count as clear
    logic [NSLOT_W-1:0] nslots;      // usable slots, already clamped
    logic               touch;       // stamp and pin one slot
    logic [SLOT_W-1:0]  touch_slot;
    logic [STAMP_W-1:0] touch_stamp;
    logic               clear_pins;  // drop all pins before pinning
  } scan_cmd_t;

  // Outcome of a victim search.
  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] victim;
  } scan_res_t;

endpackage

/* sv/eslc_lru_scan.sv */
// ----------------------------------------------------------------------------
// eslc_lru_scan
// Holds the per-slot time stamps in a synchronous memory together with the
// slot pin marks, and searches for the least recently used unpinned slot by
// reading one stamp per cycle.
// ----------------------------------------------------------------------------
module eslc_lru_scan
  import eslc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  scan_cmd_t cmd,
  output scan_res_t res
);

  typedef enum logic [1:0] {SC_IDLE, SC_RUN, SC_DRAIN} sc_state_t;

  sc_state_t          st_r;
  logic [NSLOT_W-1:0] cnt_r;
  logic [NSLOT_W-1:0] nsl_r;
  logic               first_r;
  logic               chk_vld_r;
  logic [SLOT_W-1:0]  chk_idx_r;
  logic               found_r;
  logic [SLOT_W-1:0]  best_idx_r;
  logic [STAMP_W-1:0] best_stamp_r;
  logic               done_r;

  logic [NUM_SLOTS-1:0] stamp_vld_r;
  logic [NUM_SLOTS-1:0] pin_r;
  logic [NUM_SLOTS-1:0] pin_nxt;

  logic [STAMP_W-1:0] stamp_mem [NUM_SLOTS];
  logic [STAMP_W-1:0] stamp_rdata_r;

  logic [STAMP_W-1:0] cur_stamp;
  logic               cur_pinned;
  logic               better;

  // Stamp memory: one write port for touches, one read port for the search.
  always_ff @(posedge clk) begin
    if (cmd.touch) begin
      stamp_mem[cmd.touch_slot] <= cmd.touch_stamp;
    end
    stamp_rdata_r <= stamp_mem[cnt_r[SLOT_W-1:0]];
  end

  // A slot never stamped reads as zero.
  always_comb begin
    cur_stamp  = stamp_vld_r[chk_idx_r] ? stamp_rdata_r : '0;
    cur_pinned = first_r ? 1'b0 : pin_r[chk_idx_r];
    better     = !cur_pinned && (!found_r || (cur_stamp < best_stamp_r));
  end

  // Pin marks after a touch.
  always_comb begin
    pin_nxt = cmd.clear_pins ? '0 : pin_r;
    pin_nxt[cmd.touch_slot] = 1'b1;
  end

  // Valid bits and pins.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_vld_r <= '0;
      pin_r       <= '0;
    end else if (cmd.touch) begin
      stamp_vld_r[cmd.touch_slot] <= 1'b1;
      pin_r <= pin_nxt;
    end
  end

  // Search sequencer: issue one read a cycle, compare the stamp in the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= SC_IDLE;
      done_r    <= 1'b0;
      chk_vld_r <= 1'b0;
      found_r   <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        SC_IDLE: begin
          chk_vld_r <= 1'b0;
          if (cmd.go) begin
            cnt_r   <= '0;
            found_r <= 1'b0;
            first_r <= cmd.first;
            nsl_r   <= cmd.nslots;
            if (cmd.nslots == '0) begin
              done_r <= 1'b1;
            end else begin
              st_r <= SC_RUN;
            end
          end
        end
        SC_RUN: begin
          chk_vld_r <= 1'b1;
          chk_idx_r <= cnt_r[SLOT_W-1:0];
          cnt_r     <= cnt_r + 1'b1;
          if (cnt_r == nsl_r - 1'b1) begin
            st_r <= SC_DRAIN;
          end
        end
        SC_DRAIN: begin
          chk_vld_r <= 1'b0;
          done_r    <= 1'b1;
          st_r      <= SC_IDLE;
        end
        default: begin
          st_r <= SC_IDLE;
        end
      endcase
      if (chk_vld_r && better) begin
        found_r <= 1'b1;
      end
    end
  end

  // Running minimum; the strict compare keeps the lowest index on ties.
  always_ff @(posedge clk) begin
    if (chk_vld_r && better) begin
      best_stamp_r <= cur_stamp;
      best_idx_r   <= chk_idx_r;
    end
  end

  assign res.done   = done_r;
  assign res.found  = found_r;
  assign res.victim = best_idx_r;

endmodule

/* sv/expert_slot_lru_cache_top.sv */
// ----------------------------------------------------------------------------
// expert_slot_lru_cache_top
// Maps expert ids onto cache slots with least-recently-used replacement and
// per-batch pinning, reporting the slot, hit/miss, evictions and totals.
// ----------------------------------------------------------------------------
//  channel  | handshake          | beat contents
//  ---------+--------------------+-------------------------------------------
//  input    | start, busy        | in_first_of_batch, in_expert_id
//  result   | out_valid (strobe) | out_slot, out_hit, out_status,
//           |                    | out_evicted_valid, out_evicted_expert,
//           |                    | out_hit_total, out_miss_total
//  config   | cfg_we             | cfg_addr, cfg_wdata
//
// A hit or a rejected id puts its result on the ports from ST_LOOK, once the
// map read is back. A miss that fills a slot goes through the victim search,
// ST_OWNER and ST_FILL; one with every usable slot pinned reports after the
// search, which reads one stamp per cycle over the slot count clamped to 64.
// busy stays high until the result is issued, so the next beat can be taken
// while the result is on the ports.
// Reset is synchronous and needs no clearing pass; valid bits in flip-flops
// cover the map and the slot tables. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module expert_slot_lru_cache_top
  import eslc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_first_of_batch,
  input  logic [ID_W-1:0]    in_expert_id,
  output logic               out_valid,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_hit,
  output logic [1:0]         out_status,
  output logic               out_evicted_valid,
  output logic [ID_W-1:0]    out_evicted_expert,
  output logic [TOTAL_W-1:0] out_hit_total,
  output logic [TOTAL_W-1:0] out_miss_total,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [NEXP_W-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {ST_IDLE, ST_LOOK, ST_SCAN, ST_OWNER, ST_FILL} state_t;

  state_t st_r;

  // Configuration.
  logic [NSLOT_W-1:0] slots_cfg_r;
  logic [NEXP_W-1:0]  experts_cfg_r;
  logic [NSLOT_W-1:0] nslots;
  logic [NEXP_W-1:0]  nexp;

  // Item being worked on.
  logic              first_r;
  logic [ID_W-1:0]   id_r;
  logic              bad_r;
  logic [SLOT_W-1:0] victim_r;

  // Counters.
  logic [STAMP_W-1:0] use_time_r;
  logic [TOTAL_W-1:0] hit_cnt_r;
  logic [TOTAL_W-1:0] miss_cnt_r;

  // Expert map memory and its valid bits.
  logic [SLOT_W-1:0]      map_mem [NUM_EXPERTS];
  logic [SLOT_W-1:0]      map_rdata_r;
  logic [NUM_EXPERTS-1:0] map_vld_r;
  logic                   map_we;

  // Slot owner memory and its valid bits.
  logic [ID_W-1:0]      owner_mem [NUM_SLOTS];
  logic [ID_W-1:0]      owner_rdata_r;
  logic [NUM_SLOTS-1:0] owner_vld_r;
  logic                 owner_we;

  // Registered result beat.
  logic               out_valid_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_hit_r;
  logic [1:0]         out_status_r;
  logic               out_ev_vld_r;
  logic [ID_W-1:0]    out_ev_id_r;
  logic [TOTAL_W-1:0] out_hit_tot_r;
  logic [TOTAL_W-1:0] out_miss_tot_r;

  logic      accept;
  logic      look_hit;
  logic      look_miss;
  logic      ev_vld;
  scan_cmd_t scan_cmd;
  scan_res_t scan_res;

  assign accept = start && !busy;
  assign busy   = (st_r != ST_IDLE);

  // Clamp the registers to the table sizes.
  always_comb begin
    nslots = (slots_cfg_r > NSLOT_W'(NUM_SLOTS)) ? NSLOT_W'(NUM_SLOTS) : slots_cfg_r;
    nexp   = (experts_cfg_r > NEXP_W'(NUM_EXPERTS)) ? NEXP_W'(NUM_EXPERTS) : experts_cfg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_cfg_r   <= NSLOT_W'(NUM_SLOTS);
      experts_cfg_r <= NEXP_W'(NUM_EXPERTS);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SLOTS:   slots_cfg_r   <= cfg_wdata[NSLOT_W-1:0];
        REG_EXPERTS: experts_cfg_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Lookup outcome once the map read is back.
  assign look_hit  = (st_r == ST_LOOK) && !bad_r && map_vld_r[id_r];
  assign look_miss = (st_r == ST_LOOK) && !bad_r && !map_vld_r[id_r];
  assign ev_vld    = owner_vld_r[victim_r];
  assign map_we    = (st_r == ST_FILL);
  assign owner_we  = (st_r == ST_FILL);

  // Commands to the stamp store.
  always_comb begin
    scan_cmd.go          = look_miss;
    scan_cmd.first       = first_r;
    scan_cmd.nslots      = nslots;
    scan_cmd.touch       = look_hit || (st_r == ST_FILL);
    scan_cmd.touch_slot  = look_hit ? map_rdata_r : victim_r;
    scan_cmd.touch_stamp = use_time_r + 1'b1;
    scan_cmd.clear_pins  = first_r;
  end

  eslc_lru_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (scan_cmd),
    .res   (scan_res)
  );

  // Map memory: read at the incoming id, written on a fill.
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[id_r] <= victim_r;
    end
    map_rdata_r <= map_mem[in_expert_id];
  end

  // Owner memory: read at the chosen victim, written on a fill.
  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner_mem[victim_r] <= id_r;
    end
    owner_rdata_r <= owner_mem[victim_r];
  end

  // Valid bits of both tables; the evicted expert is unmapped first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r   <= '0;
      owner_vld_r <= '0;
    end else if (st_r == ST_FILL) begin
      if (ev_vld) begin
        map_vld_r[owner_rdata_r] <= 1'b0;
      end
      map_vld_r[id_r]       <= 1'b1;
      owner_vld_r[victim_r] <= 1'b1;
    end
  end

  // Control sequencer, counters and the result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      use_time_r  <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (accept) begin
            first_r <= in_first_of_batch;
            id_r    <= in_expert_id;
            bad_r   <= ({1'b0, in_expert_id} >= nexp);
            st_r    <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (bad_r) begin
            out_valid_r    <= 1'b1;
            out_slot_r     <= '0;
            out_hit_r      <= 1'b0;
            out_status_r   <= STATUS_BAD_ID;
            out_ev_vld_r   <= 1'b0;
            out_ev_id_r    <= '0;
            out_hit_tot_r  <= hit_cnt_r;
            out_miss_tot_r <= miss_cnt_r;
            st_r           <= ST_IDLE;
          end else if (look_hit) begin
            use_time_r     <= use_time_r + 1'b1;
            hit_cnt_r      <= hit_cnt_r + 1'b1;
            out_valid_r    <= 1'b1;
            out_slot_r     <= map_rdata_r;
            out_hit_r      <= 1'b1;
            out_status_r   <= STATUS_OK;
            out_ev_vld_r   <= 1'b0;
            out_ev_id_r    <= '0;
            out_hit_tot_r  <= hit_cnt_r + 1'b1;
            out_miss_tot_r <= miss_cnt_r;
            st_r           <= ST_IDLE;
          end else begin
            st_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_res.done) begin
            if (scan_res.found) begin
              victim_r <= scan_res.victim;
              st_r     <= ST_OWNER;
            end else begin
              out_valid_r    <= 1'b1;
              out_slot_r     <= '0;
              out_hit_r      <= 1'b0;
              out_status_r   <= STATUS_NO_SLOT;
              out_ev_vld_r   <= 1'b0;
              out_ev_id_r    <= '0;
              out_hit_tot_r  <= hit_cnt_r;
              out_miss_tot_r <= miss_cnt_r;
              st_r           <= ST_IDLE;
            end
          end
        end
        ST_OWNER: begin
          // Owner read of the victim is in flight.
          st_r <= ST_FILL;
        end
        ST_FILL: begin
          use_time_r     <= use_time_r + 1'b1;
          miss_cnt_r     <= miss_cnt_r + 1'b1;
          out_valid_r    <= 1'b1;
          out_slot_r     <= victim_r;
          out_hit_r      <= 1'b0;
          out_status_r   <= STATUS_OK;
          out_ev_vld_r   <= ev_vld;
          out_ev_id_r    <= ev_vld ? owner_rdata_r : '0;
          out_hit_tot_r  <= hit_cnt_r;
          out_miss_tot_r <= miss_cnt_r + 1'b1;
          st_r           <= ST_IDLE;
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_slot           = out_slot_r;
  assign out_hit            = out_hit_r;
  assign out_status         = out_status_r;
  assign out_evicted_valid  = out_ev_vld_r;
  assign out_evicted_expert = out_ev_id_r;
  assign out_hit_total      = out_hit_tot_r;
  assign out_miss_total     = out_miss_tot_r;

  // An accepted beat always leaves the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after an input beat");

  // The victim search only reports while the sequencer waits for it.
  a_scan_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    scan_res.done |-> (st_r == ST_SCAN))
    else $error("victim search finished outside the search state");

  // Mapped experts and owned slots stay equal in number whenever the block is idle.
  a_map_owner_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> ($countones(map_vld_r) == $countones(owner_vld_r)))
    else $error("expert map and slot owner tables disagree");

  // A hit result reports the hit counter as it stands after the hit.
  a_hit_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (out_hit_tot_r == hit_cnt_r))
    else $error("hit total does not follow the hit counter");

endmodule

/* verif/slot_map_checker.sv */
// ----------------------------------------------------------------------------
// slot_map_checker
// Watches the lookup, result and register channels of the expert slot cache.
// It keeps its own copy of the expert map, slot owners, stamps and pins,
// works out the result of every accepted lookup beat and compares each result
// beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module slot_map_checker
  import eslc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_first_of_batch,
  input  logic [ID_W-1:0]    in_expert_id,
  input  logic               out_valid,
  input  logic [SLOT_W-1:0]  out_slot,
  input  logic               out_hit,
  input  logic [1:0]         out_status,
  input  logic               out_evicted_valid,
  input  logic [ID_W-1:0]    out_evicted_expert,
  input  logic [TOTAL_W-1:0] out_hit_total,
  input  logic [TOTAL_W-1:0] out_miss_total,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [NEXP_W-1:0]  cfg_wdata,
  output int                 mismatches,
  output int                 pending
);

  // One predicted result beat.
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic [1:0]         status;
    logic               ev_valid;
    logic [ID_W-1:0]    ev_expert;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
  } lookup_res_t;

  // Mirror of the cache tables and counters.
  logic [NUM_EXPERTS-1:0] mapped;
  logic [SLOT_W-1:0]      map_slot   [NUM_EXPERTS];
  logic [NUM_SLOTS-1:0]   owned;
  logic [ID_W-1:0]        slot_owner [NUM_SLOTS];
  logic [STAMP_W-1:0]     slot_stamp [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   pinned;
  logic [STAMP_W-1:0]     use_time;
  logic [TOTAL_W-1:0]     hits;
  logic [TOTAL_W-1:0]     misses;
  logic [NSLOT_W-1:0]     cfg_slots;
  logic [NEXP_W-1:0]      cfg_experts;

  lookup_res_t expected_lookups [$];
  int          mismatch_count = 0;

  assign mismatches = mismatch_count;

  // Applies one lookup to the mirror and returns the result it should give.
  function automatic lookup_res_t lookup_expert(input logic first,
                                                input logic [ID_W-1:0] id);
    lookup_res_t        r;
    int                 nslots;
    int                 nexp;
    int                 i;
    logic               found;
    logic [SLOT_W-1:0]  victim;
    logic [STAMP_W-1:0] oldest;
    logic [SLOT_W-1:0]  s;
    r      = '0;
    nslots = (cfg_slots > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_slots);
    nexp   = (cfg_experts > NUM_EXPERTS) ? NUM_EXPERTS : int'(cfg_experts);
    if (int'(id) >= nexp) begin
      // Rejected ids leave everything alone, pins included.
      r.status = STATUS_BAD_ID;
    end else if (mapped[id]) begin
      // Resident expert: restamp and pin its slot, wherever it lies.
      s = map_slot[id];
      if (first) pinned = '0;
      use_time      = use_time + 1;
      slot_stamp[s] = use_time;
      pinned[s]     = 1'b1;
      hits          = hits + 1;
      r.hit         = 1'b1;
      r.slot        = s;
    end else begin
      // Oldest unpinned usable slot, lowest index on a tie.
      found  = 1'b0;
      victim = '0;
      oldest = '0;
      for (i = 0; i < nslots; i++) begin
        if (!(pinned[i] && !first) && (!found || slot_stamp[i] < oldest)) begin
          found  = 1'b1;
          oldest = slot_stamp[i];
          victim = i[SLOT_W-1:0];
        end
      end
      if (!found) begin
        r.status = STATUS_NO_SLOT;
      end else begin
        if (first) pinned = '0;
        if (owned[victim]) begin
          r.ev_valid                 = 1'b1;
          r.ev_expert                = slot_owner[victim];
          mapped[slot_owner[victim]] = 1'b0;
        end
        map_slot[id]       = victim;
        mapped[id]         = 1'b1;
        slot_owner[victim] = id;
        owned[victim]      = 1'b1;
        use_time           = use_time + 1;
        slot_stamp[victim] = use_time;
        pinned[victim]     = 1'b1;
        misses             = misses + 1;
        r.slot             = victim;
      end
    end
    r.hit_total  = hits;
    r.miss_total = misses;
    return r;
  endfunction

  // Counts a field mismatch; only the first few are reported in full.
  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] result field %s: expected %0d, got %0d",
                 $realtime, field, want, got);
    end
  endtask

  // Results are retired before new lookups are predicted, since a result
  // beat always belongs to an earlier lookup beat.
  always @(posedge clk) begin : watch
    lookup_res_t want;
    if (!rst_n) begin
      mapped      = '0;
      owned       = '0;
      pinned      = '0;
      foreach (slot_stamp[i]) slot_stamp[i] = '0;
      use_time    = '0;
      hits        = '0;
      misses      = '0;
      cfg_slots   = 7'd64;
      cfg_experts = 9'd256;
      expected_lookups.delete();
    end else begin
      if (out_valid) begin
        if (expected_lookups.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] result beat with no lookup outstanding", $realtime);
        end else begin
          want = expected_lookups.pop_front();
          compare_field("slot", want.slot, out_slot);
          compare_field("hit", want.hit, out_hit);
          compare_field("status", want.status, out_status);
          compare_field("evicted_valid", want.ev_valid, out_evicted_valid);
          compare_field("evicted_expert", want.ev_expert, out_evicted_expert);
          compare_field("hit_total", want.hit_total, out_hit_total);
          compare_field("miss_total", want.miss_total, out_miss_total);
        end
      end
      if (cfg_we) begin
        if (cfg_addr == REG_SLOTS) cfg_slots = cfg_wdata[NSLOT_W-1:0];
        else cfg_experts = cfg_wdata;
      end
      if (start && !busy)
        expected_lookups.insert(expected_lookups.size(),
                                lookup_expert(in_first_of_batch, in_expert_id));
    end
    pending <= expected_lookups.size();
  end

endmodule

/* verif/expert_slot_lru_cache_top_tb.sv */
// ----------------------------------------------------------------------------
// expert_slot_lru_cache_top_tb
// Drives lookup beats and register writes into the expert slot cache.
// A directed opening covers hits, misses, evictions, rejected ids, a full
// pinned set, a shrunk slot count and out-of-range register values; random
// batches over small expert pools follow under several slot and id settings
// and sender idling rates. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module expert_slot_lru_cache_top_tb;
  import eslc_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_first_of_batch;
  logic [ID_W-1:0]    in_expert_id;
  logic               out_valid;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_hit;
  logic [1:0]         out_status;
  logic               out_evicted_valid;
  logic [ID_W-1:0]    out_evicted_expert;
  logic [TOTAL_W-1:0] out_hit_total;
  logic [TOTAL_W-1:0] out_miss_total;
  logic               cfg_we;
  logic               cfg_addr;
  logic [NEXP_W-1:0]  cfg_wdata;

  int lookup_errors;
  int lookups_pending;
  int sender_idle_pct = 0;
  int quiet_cycles    = 0;

  expert_slot_lru_cache_top dut (.*);

  slot_map_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_first_of_batch, .in_expert_id,
    .out_valid, .out_slot, .out_hit, .out_status, .out_evicted_valid,
    .out_evicted_expert, .out_hit_total, .out_miss_total,
    .cfg_we, .cfg_addr, .cfg_wdata,
    .mismatches(lookup_errors), .pending(lookups_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one lookup beat, idling at random, until the block takes it.
  task automatic drive_lookup(input logic first, input logic [ID_W-1:0] id);
    logic go;
    logic taken;
    in_first_of_batch <= first;
    in_expert_id      <= id;
    taken = 1'b0;
    while (!taken) begin
      go = ($urandom_range(99) >= sender_idle_pct);
      start <= go;
      @(posedge clk);
      taken = go && !busy;
    end
  endtask

  // Holds off until every outstanding result has been seen.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (lookups_pending != 0 || busy);
    repeat (2) @(posedge clk);
  endtask

  // Writes both registers back to back; only called with the block idle.
  task automatic set_config(input logic [NEXP_W-1:0] slots_w,
                            input logic [NEXP_W-1:0] experts_w);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SLOTS;
    cfg_wdata <= slots_w;
    @(posedge clk);
    cfg_addr  <= REG_EXPERTS;
    cfg_wdata <= experts_w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** expert_slot_lru_cache_top: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int               slots_w;
    int               experts_w;
    int               nsl;
    int               nex;
    int               pool;
    int               base;
    int               batch_left;
    logic             first;
    logic [ID_W-1:0]  id;
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_first_of_batch <= 1'b0;
    in_expert_id      <= '0;
    cfg_we            <= 1'b0;
    cfg_addr          <= REG_SLOTS;
    cfg_wdata         <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: fill a few slots, then hit, also at a batch start.
    drive_lookup(1'b1, 8'd0);
    drive_lookup(1'b0, 8'd255);
    drive_lookup(1'b0, 8'd0);
    drive_lookup(1'b1, 8'd255);
    drive_lookup(1'b0, 8'hAA);
    drive_lookup(1'b0, 8'h55);
    drain();

    // Two slots: a hit above the usable range, rejected ids that keep the
    // pins, evictions and a lookup with every usable slot pinned.
    set_config(9'd2, 9'd200);
    drive_lookup(1'b1, 8'hAA);
    drive_lookup(1'b0, 8'd200);
    drive_lookup(1'b1, 8'd199);
    drive_lookup(1'b1, 8'd255);
    drive_lookup(1'b0, 8'd9);
    drive_lookup(1'b0, 8'd11);
    drive_lookup(1'b1, 8'd11);
    drain();

    // No slots at all; ids above the maximum act as the maximum.
    set_config(9'd0, 9'h1FF);
    drive_lookup(1'b1, 8'd12);
    drive_lookup(1'b0, 8'd11);
    drain();

    // Slot count above the maximum; no valid ids.
    set_config(9'h1C4, 9'd0);
    drive_lookup(1'b1, 8'd0);
    drive_lookup(1'b0, 8'd255);
    drain();

    // A single slot.
    set_config(9'd1, 9'd300);
    drive_lookup(1'b1, 8'd3);
    drive_lookup(1'b0, 8'd4);
    drive_lookup(1'b1, 8'd4);

    // Random batches over a small pool of ids per phase, with some stray ids
    // and stray batch starts mixed in.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       begin slots_w = 4;   experts_w = 256; end
        1:       begin slots_w = 1;   experts_w = 20;  end
        2:       begin slots_w = 64;  experts_w = 511; end
        3:       begin slots_w = 8;   experts_w = 40;  end
        4:       begin slots_w = 2;   experts_w = 256; end
        5:       begin slots_w = 127; experts_w = 300; end
        6:       begin slots_w = 16;  experts_w = 64;  end
        default: begin slots_w = 3;   experts_w = 12;  end
      endcase
      drain();
      set_config(slots_w[NEXP_W-1:0], experts_w[NEXP_W-1:0]);
      sender_idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 46 : 13;
      nsl        = (slots_w > NUM_SLOTS) ? NUM_SLOTS : slots_w;
      nex        = (experts_w > NUM_EXPERTS) ? NUM_EXPERTS : experts_w;
      pool       = 2 * nsl + 2;
      base       = $urandom_range(255);
      batch_left = 0;
      repeat (180) begin
        if (batch_left == 0) begin
          first      = 1'b1;
          batch_left = $urandom_range(nsl + 2, 1);
        end else begin
          first = ($urandom_range(49) == 0);
        end
        batch_left--;
        if ($urandom_range(99) < 85 && nex > 0)
          id = ID_W'((base + $urandom_range(pool - 1)) % nex);
        else
          id = ID_W'($urandom_range(255));
        drive_lookup(first, id);
        if ($urandom_range(99) == 0) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (lookup_errors == 0 && lookups_pending == 0)
      $display("** expert_slot_lru_cache_top: PASSED **");
    else
      $display("** expert_slot_lru_cache_top: FAILED **");
    $finish;
  end

endmodule
